/* rtl/tpld_pkg.sv */
// Shared types and constants for the toggled piecewise-linear drive.
package tpld_pkg;

    localparam int FIELD_W  = 12;
    localparam int MAX_PTS  = 5;
    localparam int TABLE_W  = FIELD_W * MAX_PTS;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = FIELD_W;
    localparam int DIV_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMANDS  = 2'd1;

    localparam logic [TABLE_W-1:0] DIST_RESET = 60'h340_2C0_233_1C0_15A;
    localparam logic [TABLE_W-1:0] CMD_RESET  = 60'hA8F_A0C_971_971_8CD;

    localparam logic [FIELD_W-1:0] CMD_MAX = 12'hFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mult;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } sts_t;

endpackage

/* rtl/tpld_ctrl.sv */
// Controller state machine: sequences accept, multiply, divide and result load.
module tpld_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tpld_pkg::sts_t sts,
    output tpld_pkg::cmd_t cmd
);
    import tpld_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MULT:
            begin
                cmd.mult = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = !sts.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/tpld_dp.sv */
// Datapath: table registers, toggle flag, segment search, multiplier, serial divider.
module tpld_dp #(
    parameter int TABLE_POINTS = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [tpld_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tpld_pkg::TABLE_W-1:0]          cfg_data,
    input  logic                                  button_level,
    input  logic [tpld_pkg::FIELD_W-1:0]          distance,
    input  tpld_pkg::cmd_t                        cmd,
    output tpld_pkg::sts_t                        sts,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tpld_pkg::FIELD_W-1:0]          drive_command,
    output logic                                  wheel_running
);
    import tpld_pkg::*;

    logic [TABLE_W-1:0]   dist_tab_reg;
    logic [TABLE_W-1:0]   cmd_tab_reg;
    logic                 button_last_reg;
    logic                 wheel_on_reg;
    logic                 out_valid_reg;
    logic [FIELD_W-1:0]   out_cmd_reg;
    logic                 out_run_reg;

    logic                 clamp_reg;
    logic [FIELD_W-1:0]   clamp_val_reg;
    logic [FIELD_W-1:0]   c_lo_reg;
    logic [FIELD_W-1:0]   off_reg;
    logic [FIELD_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [FIELD_W-1:0]   span_reg;

    logic [FIELD_W-1:0]   rem_reg;
    logic [FIELD_W-1:0]   low_reg;
    logic [FIELD_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // segment search
    logic                 found;
    logic                 below;
    logic [FIELD_W-1:0]   d_lo;
    logic [FIELD_W-1:0]   d_hi;
    logic [FIELD_W-1:0]   c_lo;
    logic [FIELD_W-1:0]   c_hi;
    logic [FIELD_W-1:0]   c_last;

    always_comb
    begin
        found  = 1'b0;
        d_lo   = '0;
        d_hi   = '0;
        c_lo   = '0;
        c_hi   = '0;
        below  = distance < dist_tab_reg[FIELD_W-1:0];
        c_last = cmd_tab_reg[FIELD_W*(TABLE_POINTS-1) +: FIELD_W];
        // scan from the top so the lowest matching segment wins
        for (int i = TABLE_POINTS - 1; i >= 1; i--)
        begin
            if (distance < dist_tab_reg[FIELD_W*i +: FIELD_W])
            begin
                found = 1'b1;
                d_hi  = dist_tab_reg[FIELD_W*i +: FIELD_W];
                d_lo  = dist_tab_reg[FIELD_W*(i-1) +: FIELD_W];
                c_hi  = cmd_tab_reg[FIELD_W*i +: FIELD_W];
                c_lo  = cmd_tab_reg[FIELD_W*(i-1) +: FIELD_W];
            end
        end
    end

    logic [2*FIELD_W-1:0] product;
    logic [FIELD_W:0]     trial;
    logic                 take;
    logic [FIELD_W:0]     sum;
    logic [FIELD_W-1:0]   seg_val;
    logic [FIELD_W-1:0]   final_val;

    assign product = off_reg * mag_reg;
    assign trial   = {rem_reg, low_reg[FIELD_W-1]};
    assign take    = trial >= {1'b0, span_reg};
    assign sum     = {1'b0, c_lo_reg} + {1'b0, quo_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            seg_val = (quo_reg > c_lo_reg) ? '0 : c_lo_reg - quo_reg;
        end
        else
        begin
            seg_val = sum[FIELD_W] ? CMD_MAX : sum[FIELD_W-1:0];
        end
        if (!wheel_on_reg)
        begin
            final_val = '0;
        end
        else if (clamp_reg)
        begin
            final_val = clamp_val_reg;
        end
        else
        begin
            final_val = seg_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_tab_reg    <= DIST_RESET;
            cmd_tab_reg     <= CMD_RESET;
            button_last_reg <= 1'b0;
            wheel_on_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_DISTANCES)
            begin
                dist_tab_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_COMMANDS)
            begin
                cmd_tab_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                button_last_reg <= button_level;
                if (button_level && !button_last_reg)
                begin
                    wheel_on_reg <= !wheel_on_reg;
                end
            end
            if (cmd.mult)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clamp_reg     <= below || !found;
            clamp_val_reg <= below ? cmd_tab_reg[FIELD_W-1:0] : c_last;
            c_lo_reg      <= c_lo;
            off_reg       <= distance - d_lo;
            span_reg      <= d_hi - d_lo;
            neg_reg       <= c_hi < c_lo;
            mag_reg       <= (c_hi < c_lo) ? c_lo - c_hi : c_hi - c_lo;
        end
        // quotient fits in FIELD_W bits since the offset is below the span
        if (cmd.mult)
        begin
            rem_reg <= product[2*FIELD_W-1:FIELD_W];
            low_reg <= product[FIELD_W-1:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= take ? FIELD_W'(trial - {1'b0, span_reg}) : trial[FIELD_W-1:0];
            low_reg <= {low_reg[FIELD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[FIELD_W-2:0], take};
        end
        if (cmd.finish)
        begin
            out_cmd_reg <= final_val;
            out_run_reg <= wheel_on_reg;
        end
    end

    assign sts.div_last = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign drive_command = out_cmd_reg;
    assign wheel_running = out_run_reg;

endmodule

/* rtl/toggled_piecewise_linear_drive_top.sv */
// Order: accept, multiply, 12-step restoring divide, then result register load.
// One request at a time; the result load waits while the last result is stalled.
// A finished result waits in the output register while the next request is taken.
// Reset: rst_n asynchronous, active low; wheel off, button level low,
// breakpoint tables back to their default values.
module toggled_piecewise_linear_drive_top #(
    parameter int TABLE_POINTS = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,   // button_level, distance
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,   // drive_command, wheel_running
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tpld_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tpld_pkg::TABLE_W-1:0]          cfg_data
);
    import tpld_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [FIELD_W-1:0] drive_command;
    logic               wheel_running;

    assign cfg_ready = 1'b1;

    tpld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tpld_dp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .button_level  (s_tdata[0]),
        .distance      (s_tdata[FIELD_W:1]),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .drive_command (drive_command),
        .wheel_running (wheel_running)
    );

    assign m_tdata = {3'b000, wheel_running, drive_command};

endmodule

/* rtl/tpld_chk.sv */
// Port-level checker for the drive top level, with its bind.
module tpld_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // one request in flight: s_tready drops after each accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##1 !s_tready ##1 !s_tready)
        else $error("request accepted while another is in progress");

    // drive is zero whenever the wheel is reported off
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[12] |-> m_tdata[11:0] == 12'd0)
        else $error("nonzero drive with wheel off");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:13] == 3'd0)
        else $error("pad bits of result not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind toggled_piecewise_linear_drive_top tpld_chk u_tpld_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/toggled_piecewise_linear_drive_top_test.sv */
// Self-checking testbench for the toggled piecewise-linear drive block.
`timescale 1ns / 1ps

module toggled_piecewise_linear_drive_top_test;

    import tpld_pkg::*;

    localparam int PTS = 5;
    localparam int SEGMENTS = 10;
    localparam int SEGMENT_ITEMS = 185;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT = 5000;

    // Indexes past the two registers; the block must drop these writes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [TABLE_W-1:0] TABLE_ONES = {TABLE_W{1'b1}};
    localparam logic [TABLE_W-1:0] TABLE_ZERO = '0;

    typedef enum logic { ROW_STEP, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [TABLE_W-1:0]     value;
        logic                   button;
        logic [FIELD_W-1:0]     distance;
        bit                     typed;
        logic [FIELD_W-1:0]     cmd;
        logic                   running;
    } drive_row_t;

    typedef struct {
        logic [FIELD_W-1:0] cmd;
        logic               running;
    } drive_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;   // button_level, distance
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [15:0]            m_tdata;        // drive_command, wheel_running
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TABLE_W-1:0]     cfg_data = '0;

    // Side band that travels with each request: typed expectation, if any.
    bit                     req_typed = 1'b0;
    logic [FIELD_W-1:0]     req_cmd = '0;
    logic                   req_running = 1'b0;

    logic [TABLE_W-1:0]     dist_table;
    logic [TABLE_W-1:0]     cmd_table;
    logic                   wheel_on_q;
    logic                   button_last_q;
    drive_result_t          pending_drive[$];

    int                     send_idle = 0;
    int                     recv_idle = 0;
    int                     err_count = 0;
    int                     stall_cycles = 0;
    logic                   gen_button = 1'b0;
    drive_row_t             steps[$];

    toggled_piecewise_linear_drive_top #(
        .TABLE_POINTS(PTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [FIELD_W-1:0] interp_command(input logic [FIELD_W-1:0] dist_in);
        longint d_lo;
        longint d_hi;
        longint c_lo;
        longint c_hi;
        longint level;
        bit     found;
        found = 1'b0;
        if (dist_in < dist_table[FIELD_W-1:0])
            return cmd_table[FIELD_W-1:0];
        level = longint'(cmd_table[FIELD_W*(PTS-1) +: FIELD_W]);
        for (int i = 1; i < PTS; i++)
        begin
            d_hi = longint'(dist_table[FIELD_W*i +: FIELD_W]);
            if (!found && longint'(dist_in) < d_hi)
            begin
                d_lo = longint'(dist_table[FIELD_W*(i-1) +: FIELD_W]);
                c_lo = longint'(cmd_table[FIELD_W*(i-1) +: FIELD_W]);
                c_hi = longint'(cmd_table[FIELD_W*i +: FIELD_W]);
                // Signed quotient truncates toward zero on a falling segment.
                level = c_lo + ((longint'(dist_in) - d_lo) * (c_hi - c_lo)) / (d_hi - d_lo);
                found = 1'b1;
            end
        end
        if (level < 0)
            level = 0;
        if (level > 4095)
            level = 4095;
        return level[FIELD_W-1:0];
    endfunction

    // Track config, predict on each accepted request, check each result.
    always @(posedge clk or negedge rst_n)
    begin
        drive_result_t exp_r;
        logic          btn;
        if (!rst_n)
        begin
            dist_table    <= DIST_RESET;
            cmd_table     <= CMD_RESET;
            wheel_on_q    <= 1'b0;
            button_last_q <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DISTANCES)
                    dist_table <= cfg_data;
                else if (cfg_index == CFG_COMMANDS)
                    cmd_table <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                btn = s_tdata[0];
                exp_r.running = (btn && !button_last_q) ? !wheel_on_q : wheel_on_q;
                exp_r.cmd = exp_r.running ? interp_command(s_tdata[FIELD_W:1]) : '0;
                if (req_typed)
                begin
                    exp_r.cmd = req_cmd;
                    exp_r.running = req_running;
                end
                wheel_on_q    <= (btn && !button_last_q) ? !wheel_on_q : wheel_on_q;
                button_last_q <= btn;
                pending_drive.push_back(exp_r);
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_drive.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual cmd %h run %b",
                             $time, m_tdata[FIELD_W-1:0], m_tdata[FIELD_W]);
                    err_count++;
                end
                else
                begin
                    exp_r = pending_drive.pop_front();
                    if (m_tdata[FIELD_W-1:0] !== exp_r.cmd)
                    begin
                        $display("%0t drive_command mismatch: expected %h actual %h",
                                 $time, exp_r.cmd, m_tdata[FIELD_W-1:0]);
                        err_count++;
                    end
                    if (m_tdata[FIELD_W] !== exp_r.running)
                    begin
                        $display("%0t wheel_running mismatch: expected %b actual %b",
                                 $time, exp_r.running, m_tdata[FIELD_W]);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain_results();
        while (pending_drive.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [TABLE_W-1:0] value);
        drain_results();
        // Let the datapath settle before touching the tables.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input logic button, input logic [FIELD_W-1:0] dist_in,
                                input bit typed, input logic [FIELD_W-1:0] cmd,
                                input logic running);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {3'b000, dist_in, button};
        req_typed   <= typed;
        req_cmd     <= cmd;
        req_running <= running;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        drain_results();
    endtask

    function automatic logic [TABLE_W-1:0] rising_distances();
        logic [TABLE_W-1:0] packed_d;
        int                 d;
        d = $urandom_range(0, 1000);
        for (int i = 0; i < MAX_PTS; i++)
        begin
            packed_d[FIELD_W*i +: FIELD_W] = d[FIELD_W-1:0];
            d = d + $urandom_range(1, 750);
        end
        return packed_d;
    endfunction

    function automatic logic [TABLE_W-1:0] random_table();
        return TABLE_W'({$urandom, $urandom});
    endfunction

    function automatic logic [FIELD_W-1:0] pick_distance();
        int pick;
        int d;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        if (pick < 50)
        begin
            // Land on or next to a breakpoint.
            d = int'(dist_table[FIELD_W*$urandom_range(0, PTS-1) +: FIELD_W]);
            d = d + $urandom_range(0, 4) - 2;
            if (d < 0)
                d = 0;
            if (d > 4095)
                d = 4095;
            return d[FIELD_W-1:0];
        end
        return FIELD_W'($urandom_range(0, 4095));
    endfunction

    task automatic load_tables(input int seg);
        case (seg % 5)
            0:
            begin
                write_register(CFG_DISTANCES, DIST_RESET);
                write_register(CFG_COMMANDS, CMD_RESET);
            end
            1:
            begin
                write_register(CFG_DISTANCES, rising_distances());
                write_register(CFG_COMMANDS, random_table());
            end
            2:
            begin
                write_register(CFG_DISTANCES, random_table());
                write_register(CFG_COMMANDS, random_table());
            end
            3:
            begin
                write_register(CFG_DISTANCES, rising_distances());
                write_register(CFG_COMMANDS, ($urandom_range(1) != 0) ? TABLE_ONES : TABLE_ZERO);
            end
            default:
            begin
                write_register(CFG_DISTANCES, ($urandom_range(1) != 0) ? TABLE_ONES : TABLE_ZERO);
                write_register(CFG_COMMANDS, random_table());
            end
        endcase
        if ($urandom_range(2) == 0)
            write_register($urandom_range(1) != 0 ? CFG_SPARE_A : CFG_SPARE_B, random_table());
    endtask

    task automatic add_step(input logic button, input logic [FIELD_W-1:0] dist_in,
                            input bit typed, input logic [FIELD_W-1:0] cmd,
                            input logic running);
        drive_row_t r;
        r.kind = ROW_STEP;
        r.index = '0;
        r.value = '0;
        r.button = button;
        r.distance = dist_in;
        r.typed = typed;
        r.cmd = cmd;
        r.running = running;
        steps.push_back(r);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [TABLE_W-1:0] value);
        drive_row_t r;
        r.kind = ROW_WRITE;
        r.index = index;
        r.value = value;
        r.button = 1'b0;
        r.distance = '0;
        r.typed = 1'b0;
        r.cmd = '0;
        r.running = 1'b0;
        steps.push_back(r);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default tables: wheel starts off, toggles on rising edges only.
        add_step(1'b0, 12'hFFF, 1, 12'h000, 1'b0);
        add_step(1'b1, 12'h000, 1, 12'h8CD, 1'b1);
        add_step(1'b1, 12'hFFF, 1, 12'hA8F, 1'b1);
        add_step(1'b0, 12'h15A, 0, '0, 1'b0);
        add_step(1'b0, 12'h1C0, 0, '0, 1'b0);
        add_step(1'b0, 12'h232, 0, '0, 1'b0);
        add_step(1'b0, 12'h2C5, 0, '0, 1'b0);
        add_step(1'b1, 12'h300, 1, 12'h000, 1'b0);
        add_step(1'b1, 12'hFFF, 1, 12'h000, 1'b0);
        add_step(1'b0, 12'h555, 1, 12'h000, 1'b0);
        add_step(1'b1, 12'h340, 1, 12'hA8F, 1'b1);
        // Out-of-range index: tables must stay as they are.
        add_write(CFG_SPARE_B, TABLE_ONES);
        add_step(1'b1, 12'h000, 1, 12'h8CD, 1'b1);
        add_write(CFG_DISTANCES, TABLE_ONES);
        add_step(1'b0, 12'hFFE, 1, 12'h8CD, 1'b1);
        add_step(1'b0, 12'hFFF, 1, 12'hA8F, 1'b1);
        add_write(CFG_DISTANCES, TABLE_ZERO);
        add_step(1'b0, 12'h000, 1, 12'hA8F, 1'b1);
        // Non-increasing distances with falling command segments.
        add_write(CFG_DISTANCES, {12'h800, 12'h300, 12'h400, 12'h080, 12'h100});
        add_write(CFG_COMMANDS, {12'h000, 12'h200, 12'hFFF, 12'h800, 12'hFFF});
        add_step(1'b0, 12'h150, 0, '0, 1'b0);
        add_step(1'b0, 12'h350, 0, '0, 1'b0);
        add_step(1'b0, 12'h500, 0, '0, 1'b0);
        add_step(1'b0, 12'h0A0, 1, 12'hFFF, 1'b1);
        add_step(1'b1, 12'h900, 1, 12'h000, 1'b0);

        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_WRITE)
            begin
                hold_until_drained();
                write_register(steps[i].index, steps[i].value);
            end
            else
                send_request(steps[i].button, steps[i].distance, steps[i].typed,
                             steps[i].cmd, steps[i].running);
        end
        gen_button = 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            hold_until_drained();
            load_tables(seg);
            if (seg < 3)
            begin
                send_idle = 26;
                recv_idle = 66;
            end
            else if (seg < 6)
            begin
                send_idle = 66;
                recv_idle = 26;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                if ((seg == 1 && n == 90) || $urandom_range(299) == 0)
                    hold_until_drained();
                if ($urandom_range(99) < 35)
                    gen_button = !gen_button;
                send_request(gen_button, pick_distance(), 0, '0, 1'b0);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_drive.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
